[design/bsvp_pkg.sv]
package bsvp_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] MAX_SIZE_RST = 5'd10;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_PURGE = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic pop_fin;
    logic purge_run;
    logic purge_fin;
    logic load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic purge_end;
  } sts_t;

endpackage

[design/bsvp_cmd_if.sv]
interface bsvp_cmd_if #(
  parameter int W = bsvp_pkg::WIDTH_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic [bsvp_pkg::FUNC_W-1:0] func;
  logic signed [W-1:0]        value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

[design/bsvp_rsp_if.sv]
interface bsvp_rsp_if #(
  parameter int W  = bsvp_pkg::WIDTH_DEF,
  parameter int CW = $clog2(bsvp_pkg::DEPTH_DEF + 1)
) ();
  logic                        valid;
  logic                        ready;
  logic [bsvp_pkg::STAT_W-1:0] status;
  logic signed [W-1:0]         popped_value;
  logic [CW-1:0]               count;
  logic                        is_full;

  modport source (output valid, output status, output popped_value, output count,
                  output is_full, input ready);
  modport sink (input valid, input status, input popped_value, input count,
                input is_full, output ready);
endinterface

[design/bsvp_ctrl.sv]
module bsvp_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [bsvp_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bsvp_pkg::ctl_t              ctl,
  input  bsvp_pkg::sts_t              sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_PURGE
  } state_t;

  state_t state;
  logic   accept;

  always_comb begin
    in_ready      = (state == S_IDLE) && (!out_valid || out_ready);
    accept        = in_valid && in_ready;
    ctl.accept    = accept;
    ctl.pop_fin   = (state == S_POP);
    ctl.purge_run = (state == S_PURGE);
    ctl.purge_fin = (state == S_PURGE) && sts.purge_end;
    // Push, clear and a pop on an empty stack finish at the accept edge.
    ctl.load = (accept && ((in_func == bsvp_pkg::FUNC_PUSH) ||
                           (in_func == bsvp_pkg::FUNC_CLEAR) ||
                           ((in_func == bsvp_pkg::FUNC_POP) && sts.empty)))
               || ctl.pop_fin || ctl.purge_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (in_func == bsvp_pkg::FUNC_POP) && !sts.empty) begin
            state <= S_POP;
          end else if (accept && (in_func == bsvp_pkg::FUNC_PURGE)) begin
            state <= S_PURGE;
          end
        end
        S_POP: begin
          state <= S_IDLE;
        end
        S_PURGE: begin
          if (sts.purge_end) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ctl.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/bsvp_dp.sv]
module bsvp_dp #(
  parameter int DEPTH = bsvp_pkg::DEPTH_DEF,
  parameter int WIDTH = bsvp_pkg::WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [bsvp_pkg::CFG_W-1:0]         cfg_wr_data,
  input  bsvp_pkg::ctl_t                     ctl,
  output bsvp_pkg::sts_t                     sts,
  input  logic [bsvp_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [WIDTH-1:0]            in_value,
  output logic [bsvp_pkg::STAT_W-1:0]        res_status,
  output logic signed [WIDTH-1:0]            res_popped,
  output logic [$clog2(DEPTH + 1)-1:0]       res_count,
  output logic                               res_full
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = (CNT_W > bsvp_pkg::CFG_W) ? CNT_W : bsvp_pkg::CFG_W;

  logic [WIDTH-1:0]           mem [DEPTH];
  logic [bsvp_pkg::CFG_W-1:0] max_size;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           cnt_dec;
  logic [CNT_W-1:0]           lim;
  logic [CNT_W-1:0]           rd;
  logic [CNT_W-1:0]           wr;
  logic                       pend;
  logic [WIDTH-1:0]           pval;
  logic [WIDTH-1:0]           rdata;
  logic                       full;
  logic                       empty;
  logic                       rd_more;
  logic                       we;
  logic [AW-1:0]              wa;
  logic [WIDTH-1:0]           wd;
  logic                       re;
  logic [AW-1:0]              ra;
  logic                       keep;
  logic [bsvp_pkg::STAT_W-1:0] stat_calc;

  always_comb begin
    // A limit above the physical depth acts as the depth.
    if (LW'(max_size) > LW'(DEPTH)) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = CNT_W'(max_size);
    end
    full    = (count >= lim);
    empty   = (count == '0);
    cnt_dec = count - 1'b1;
    rd_more = (rd < count);
    keep    = pend && (rdata != pval);

    sts.empty     = empty;
    sts.purge_end = !rd_more && !pend;

    count_next = count;
    stat_calc  = bsvp_pkg::ST_OK;
    if (ctl.accept) begin
      case (in_func)
        bsvp_pkg::FUNC_PUSH: begin
          if (full) begin
            stat_calc = bsvp_pkg::ST_FULL;
          end else begin
            count_next = count + 1'b1;
          end
        end
        bsvp_pkg::FUNC_POP: begin
          if (empty) begin
            stat_calc = bsvp_pkg::ST_EMPTY;
          end else begin
            count_next = cnt_dec;
          end
        end
        bsvp_pkg::FUNC_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
    if (ctl.purge_fin) begin
      count_next = wr;
    end

    we = 1'b0;
    wa = count[AW-1:0];
    wd = in_value;
    if (ctl.accept && (in_func == bsvp_pkg::FUNC_PUSH) && !full) begin
      we = 1'b1;
    end else if (ctl.purge_run && keep) begin
      we = 1'b1;
      wa = wr[AW-1:0];
      wd = rdata;
    end

    re = 1'b0;
    ra = cnt_dec[AW-1:0];
    if (ctl.accept && (in_func == bsvp_pkg::FUNC_POP) && !empty) begin
      re = 1'b1;
    end else if (ctl.purge_run && rd_more) begin
      re = 1'b1;
      ra = rd[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= bsvp_pkg::MAX_SIZE_RST;
      count    <= '0;
      rd       <= '0;
      wr       <= '0;
      pend     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_size <= cfg_wr_data;
      end
      count <= count_next;
      if (ctl.accept && (in_func == bsvp_pkg::FUNC_PURGE)) begin
        rd   <= '0;
        wr   <= '0;
        pend <= 1'b0;
      end else if (ctl.purge_run) begin
        if (rd_more) begin
          rd <= rd + 1'b1;
        end
        pend <= rd_more;
        if (keep) begin
          wr <= wr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && (in_func == bsvp_pkg::FUNC_PURGE)) begin
      pval <= in_value;
    end
    if (ctl.load) begin
      res_status <= stat_calc;
      res_popped <= ctl.pop_fin ? rdata : '0;
      res_count  <= count_next;
      res_full   <= (count_next >= lim);
    end
  end

endmodule

[design/bounded_stack_with_value_purge_top.sv]
// Bounded LIFO stack of signed words with a purge-by-value command.
// Requests arrive on the cmd channel (valid/ready, fields func and value):
// push, pop, clear, or purge every entry equal to value. Every request yields
// exactly one result on the res channel with a status, the popped value, the
// entry count after the request and a full flag.
// The limit register is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, which the block itself does not
// enforce. A limit above DEPTH acts as DEPTH. Push, clear and a pop on an
// empty stack load the result register at the acceptance edge. A pop passes
// through state S_POP for the registered read of the entry memory; a purge
// stays in S_PURGE and walks the entries through the single read port of
// the entry memory, one entry per cycle, compacting the survivors in place.
// One request is in flight at a time; the next request is taken in the cycle
// its predecessor's result leaves the output register, so a push or clear
// stream sustains one request per cycle when the receiver keeps ready high.
// When the receiver stalls, the result holds in the output register and cmd
// ready stays low until it is taken.
// Reset empties the stack and sets the limit to ten. Entry contents are not
// cleared; only entries below the count are ever read.
module bounded_stack_with_value_purge_top #(
  parameter int DEPTH = bsvp_pkg::DEPTH_DEF,
  parameter int WIDTH = bsvp_pkg::WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [bsvp_pkg::CFG_W-1:0] cfg_wr_data,
  bsvp_cmd_if.sink                   cmd,
  bsvp_rsp_if.source                 res
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  bsvp_pkg::ctl_t ctl;
  bsvp_pkg::sts_t sts;

  // The controller sequences each request and owns the handshake flags.
  bsvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_func   (cmd.func),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // The datapath holds the entry memory, the count, the limit and the result.
  bsvp_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .sts         (sts),
    .in_func     (cmd.func),
    .in_value    (cmd.value),
    .res_status  (res.status),
    .res_popped  (res.popped_value),
    .res_count   (res.count),
    .res_full    (res.is_full)
  );

  // The count can never pass the physical depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.count <= CNT_W'(DEPTH)))
    else $error("result count exceeds depth");

  // A failed pop only happens on an empty stack.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == bsvp_pkg::ST_EMPTY)) |-> (res.count == '0))
    else $error("pop failure reported with entries present");

  // A refused push only happens when the stack is full.
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == bsvp_pkg::ST_FULL)) |-> res.is_full)
    else $error("push refused while not full");

  // While a request is being worked on, no new request is taken.
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop_fin || ctl.purge_run) |-> !cmd.ready)
    else $error("request accepted during pop or purge");

endmodule

[dv/tb_bounded_stack_with_value_purge_top.sv]
`timescale 1ns / 100ps

module tb_bounded_stack_with_value_purge_top;

  localparam int STACK_DEPTH = bsvp_pkg::DEPTH_DEF;
  localparam int WORD_W = bsvp_pkg::WIDTH_DEF;
  localparam int COUNT_W = $clog2(bsvp_pkg::DEPTH_DEF + 1);
  // Cycle limit at which a hung run is stopped.
  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNK_REQUESTS = 80;

  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};

  // One result as the block should report it.
  typedef struct packed {
    logic [bsvp_pkg::STAT_W-1:0] status;
    logic signed [WORD_W-1:0] popped;
    logic [COUNT_W-1:0] count;
    logic full;
  } stack_reply_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [bsvp_pkg::CFG_W-1:0] cfg_wr_data;

  bsvp_cmd_if cmd_ch ();
  bsvp_rsp_if res_ch ();

  bounded_stack_with_value_purge_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Our own copy of the stack: entries from the bottom up, the number held,
  // and the limit register exactly as it was last written.
  logic signed [WORD_W-1:0] shadow_entries [STACK_DEPTH];
  int shadow_depth;
  logic [bsvp_pkg::CFG_W-1:0] shadow_limit;

  // Results that accepted requests still owe us, oldest first.
  stack_reply_t replies_due[$];
  stack_reply_t due_reply;

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the result of one request and advance the shadow stack.
  // A limit above the depth behaves as the depth; a limit of zero makes the
  // stack full while empty; a limit lowered below the count keeps the entries.
  function automatic stack_reply_t apply_stack_request(
      input logic [bsvp_pkg::FUNC_W-1:0] op,
      input logic signed [WORD_W-1:0] val);
    stack_reply_t reply;
    int cap;
    int keep;
    cap = (shadow_limit > STACK_DEPTH) ? STACK_DEPTH : int'(shadow_limit);
    reply.status = bsvp_pkg::ST_OK;
    reply.popped = '0;
    case (op)
      bsvp_pkg::FUNC_PUSH: begin
        if (shadow_depth >= cap || shadow_depth >= STACK_DEPTH) begin
          reply.status = bsvp_pkg::ST_FULL;
        end else begin
          shadow_entries[shadow_depth] = val;
          shadow_depth++;
        end
      end
      bsvp_pkg::FUNC_POP: begin
        if (shadow_depth == 0) begin
          reply.status = bsvp_pkg::ST_EMPTY;
        end else begin
          shadow_depth--;
          reply.popped = shadow_entries[shadow_depth];
        end
      end
      bsvp_pkg::FUNC_CLEAR: begin
        shadow_depth = 0;
      end
      default: begin
        // Survivors slide down and keep their bottom-to-top order.
        keep = 0;
        for (int rd = 0; rd < shadow_depth; rd++) begin
          if (shadow_entries[rd] != val) begin
            shadow_entries[keep] = shadow_entries[rd];
            keep++;
          end
        end
        shadow_depth = keep;
      end
    endcase
    reply.count = COUNT_W'(shadow_depth);
    reply.full = (shadow_depth >= cap);
    return reply;
  endfunction

  // Values cluster around a few small numbers so that purges find repeats,
  // with the word extremes and fully random words mixed in.
  function automatic logic signed [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) begin
      return WORD_W'(int'($urandom_range(7)) - 4);
    end else if (roll < 65) begin
      case ($urandom_range(3))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Offer one request, hold it until the block takes it, then record what it
  // must produce. Valid stays high afterwards so that back-to-back requests
  // never lower and raise it within one time step.
  task automatic send_request(input logic [bsvp_pkg::FUNC_W-1:0] op,
                              input logic signed [WORD_W-1:0] val);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= op;
    cmd_ch.value <= val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    replies_due.push_back(apply_stack_request(op, val));
  endtask

  // Stop offering requests and wait until every owed result has arrived,
  // which leaves the block idle.
  task automatic drain_requests();
    cmd_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Write the limit register; the caller makes sure the block is idle.
  task automatic write_limit(input logic [bsvp_pkg::CFG_W-1:0] lim);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_limit = lim;
  endtask

  // Every command on an empty stack, the word extremes, a purge that must
  // keep order, and alternating-bit patterns in both phases.
  task automatic test_directed_commands();
    send_request(bsvp_pkg::FUNC_POP, WORD_MAX);
    send_request(bsvp_pkg::FUNC_PURGE, '0);
    send_request(bsvp_pkg::FUNC_CLEAR, WORD_MIN);
    send_request(bsvp_pkg::FUNC_PUSH, WORD_MIN);
    send_request(bsvp_pkg::FUNC_PUSH, WORD_MAX);
    send_request(bsvp_pkg::FUNC_PUSH, '0);
    send_request(bsvp_pkg::FUNC_PUSH, WORD_MAX);
    send_request(bsvp_pkg::FUNC_PUSH, '1);
    // Both copies of the maximum go; the minimum, zero and minus one remain.
    send_request(bsvp_pkg::FUNC_PURGE, WORD_MAX);
    send_request(bsvp_pkg::FUNC_POP, '0);
    send_request(bsvp_pkg::FUNC_POP, '0);
    send_request(bsvp_pkg::FUNC_PUSH, 32'h5555_5555);
    send_request(bsvp_pkg::FUNC_PUSH, 32'hAAAA_AAAA);
    send_request(bsvp_pkg::FUNC_POP, '0);
    send_request(bsvp_pkg::FUNC_CLEAR, '0);
    drain_requests();
  endtask

  // A limit of zero, a limit that is reached, and a limit lowered below the
  // count while entries are held.
  task automatic test_limit_corners();
    write_limit(5'd0);
    send_request(bsvp_pkg::FUNC_PUSH, 32'd7);
    drain_requests();
    write_limit(5'd2);
    send_request(bsvp_pkg::FUNC_PUSH, 32'd7);
    send_request(bsvp_pkg::FUNC_PUSH, 32'd8);
    send_request(bsvp_pkg::FUNC_PUSH, 32'd9);
    drain_requests();
    write_limit(5'd1);
    send_request(bsvp_pkg::FUNC_PUSH, 32'd10);
    send_request(bsvp_pkg::FUNC_POP, '0);
    send_request(bsvp_pkg::FUNC_PURGE, 32'd7);
    drain_requests();
  endtask

  // Random requests at one pair of idle rates. The limit changes between
  // chunks while the stack keeps its contents, so the count often ends up at
  // or above a freshly lowered limit.
  task automatic test_random_mix(input int send_pct, input int stall_pct);
    int roll;
    logic [bsvp_pkg::FUNC_W-1:0] op;
    logic signed [WORD_W-1:0] val;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int chunk = 0; chunk < 6; chunk++) begin
      case (chunk)
        0: write_limit(5'd16);
        1: write_limit(5'd31);
        2: write_limit(5'd1);
        3: write_limit(bsvp_pkg::CFG_W'($urandom_range(31)));
        4: write_limit(bsvp_pkg::CFG_W'($urandom_range(15, 2)));
        default: write_limit(bsvp_pkg::CFG_W'($urandom_range(30, 17)));
      endcase
      for (int n = 0; n < CHUNK_REQUESTS; n++) begin
        roll = $urandom_range(99);
        val = pick_word();
        if (roll < 48) begin
          op = bsvp_pkg::FUNC_PUSH;
        end else if (roll < 73) begin
          op = bsvp_pkg::FUNC_POP;
        end else if (roll < 78) begin
          op = bsvp_pkg::FUNC_CLEAR;
        end else begin
          op = bsvp_pkg::FUNC_PURGE;
          // Mostly purge a value that is actually held.
          if (shadow_depth > 0 && $urandom_range(99) < 65) begin
            val = shadow_entries[$urandom_range(shadow_depth - 1)];
          end
        end
        send_request(op, val);
      end
      drain_requests();
    end
  endtask

  // The receiver drops ready at the current stall rate.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result taken is compared with the oldest owed result.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result: status %0d, popped_value %0d, count %0d, is_full %0d",
               res_ch.status, $signed(res_ch.popped_value), res_ch.count, res_ch.is_full);
        mismatch_count++;
      end else begin
        due_reply = replies_due.pop_front();
        if (res_ch.status !== due_reply.status) begin
          $error("status: expected %0d, actual %0d", due_reply.status, res_ch.status);
          mismatch_count++;
        end
        if (res_ch.popped_value !== due_reply.popped) begin
          $error("popped_value: expected %0d, actual %0d", $signed(due_reply.popped),
                 $signed(res_ch.popped_value));
          mismatch_count++;
        end
        if (res_ch.count !== due_reply.count) begin
          $error("count: expected %0d, actual %0d", due_reply.count, res_ch.count);
          mismatch_count++;
        end
        if (res_ch.is_full !== due_reply.full) begin
          $error("is_full: expected %0d, actual %0d", due_reply.full, res_ch.is_full);
          mismatch_count++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_depth = 0;
    shadow_limit = bsvp_pkg::MAX_SIZE_RST;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.func <= bsvp_pkg::FUNC_PUSH;
    cmd_ch.value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_commands();
    test_limit_corners();
    test_random_mix(10, 88);
    test_random_mix(88, 10);
    test_random_mix(0, 0);

    // A purge of a full stack is the slowest request; allow for a stray one.
    drain_requests();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
